[rtl/sbdc_pkg.sv]
package sbdc_pkg;

   localparam int PosWidth   = 25;
   localparam int PressWidth = 17;
   localparam int PubWidth   = 11;
   localparam int IvlWidth   = 16;

   localparam logic [PosWidth-1:0]   FULL_TRAVEL  = 25'd16777216;
   localparam logic [PosWidth-1:0]   HALF_TRAVEL  = 25'd8388608;
   localparam logic [PubWidth-1:0]   PUBLISH_MS   = 11'd1000;
   localparam logic [PressWidth-1:0] PRESS_MAX    = 17'd131071;
   localparam logic [PubWidth-1:0]   PUB_MAX      = 11'd2047;
   localparam logic [PosWidth-1:0]   STEP_RESET   = 25'd839;
   localparam logic [IvlWidth-1:0]   IVL_RESET    = 16'd1000;

   localparam logic [1:0] MOT_IDLE    = 2'd0;
   localparam logic [1:0] MOT_OPENING = 2'd1;
   localparam logic [1:0] MOT_CLOSING = 2'd2;

   localparam logic [1:0] TGT_IDLE  = 2'd0;
   localparam logic [1:0] TGT_OPEN  = 2'd1;
   localparam logic [1:0] TGT_CLOSE = 2'd2;
   localparam logic [1:0] TGT_NONE  = 2'd3;

   localparam logic DIR_CLOSING = 1'b0;
   localparam logic DIR_OPENING = 1'b1;

   localparam logic [2:0] FN_TICK       = 3'd0;
   localparam logic [2:0] FN_POSITION   = 3'd1;
   localparam logic [2:0] FN_STOP       = 3'd2;
   localparam logic [2:0] FN_OPEN_HIT   = 3'd3;
   localparam logic [2:0] FN_OPEN_LEFT  = 3'd4;
   localparam logic [2:0] FN_CLOSE_HIT  = 3'd5;
   localparam logic [2:0] FN_CLOSE_LEFT = 3'd6;

   localparam logic [1:0] CSR_OPEN_STEP  = 2'd0;
   localparam logic [1:0] CSR_CLOSE_STEP = 2'd1;
   localparam logic [1:0] CSR_INTERVAL   = 2'd2;

   typedef struct packed {
      logic [PosWidth-1:0] open_step;
      logic [PosWidth-1:0] close_step;
      logic [IvlWidth-1:0] interval;
   } sbdc_cfg_type;

   typedef struct packed {
      logic [PosWidth-1:0]   position;
      logic [1:0]            motion;
      logic [1:0]            pending;
      logic                  prev_dir;
      logic [PressWidth-1:0] since_press;
      logic [PubWidth-1:0]   since_pub;
   } sbdc_state_type;

   typedef struct packed {
      logic                publish;
      logic                actuate;
      logic [1:0]          movement;
      logic [PosWidth-1:0] position;
   } sbdc_result_type;

endpackage

[rtl/sbdc_step.sv]
module sbdc_step (
   input  sbdc_pkg::sbdc_state_type  state,
   input  sbdc_pkg::sbdc_cfg_type    cfg,
   input  logic [2:0]                func,
   input  logic [24:0]               target_position,
   output sbdc_pkg::sbdc_state_type  state_next,
   output sbdc_pkg::sbdc_result_type result
);
   import sbdc_pkg::*;

   logic [PosWidth-1:0] target_sat;
   logic [PosWidth:0]   open_sum;
   logic                wants_press;
   logic                press;

   assign target_sat = (target_position > FULL_TRAVEL) ? FULL_TRAVEL : target_position;
   assign open_sum   = {1'b0, state.position} + {1'b0, cfg.open_step};

   always_comb begin
      state_next     = state;
      result.actuate = 1'b0;
      result.publish = 1'b0;
      wants_press    = 1'b0;
      press          = 1'b0;

      unique case (func)
         FN_TICK: begin
            if (state.since_press != PRESS_MAX) begin
               state_next.since_press = state.since_press + PressWidth'(1);
            end
            if (state.since_pub != PUB_MAX) begin
               state_next.since_pub = state.since_pub + PubWidth'(1);
            end
            wants_press = (state.pending != TGT_NONE) && (state.pending != state.motion);
            press = wants_press && (state_next.since_press > {1'b0, cfg.interval});
            if (press) begin
               // Each press steps the cycle open, stop, close, stop.
               if (state.motion != MOT_IDLE) begin
                  state_next.motion = MOT_IDLE;
               end else if (state.prev_dir == DIR_OPENING) begin
                  state_next.motion   = MOT_CLOSING;
                  state_next.prev_dir = DIR_CLOSING;
               end else begin
                  state_next.motion   = MOT_OPENING;
                  state_next.prev_dir = DIR_OPENING;
               end
               result.actuate         = 1'b1;
               result.publish         = 1'b1;
               state_next.since_press = '0;
               state_next.since_pub   = '0;
            end else if (!wants_press && state.pending == state.motion) begin
               state_next.pending = TGT_NONE;
            end
            // The press tick rebases time, so it adds no travel.
            if (!press) begin
               if (state.motion == MOT_OPENING) begin
                  state_next.position = (open_sum > {1'b0, FULL_TRAVEL}) ? FULL_TRAVEL
                                                                           : open_sum[PosWidth-1:0];
               end else if (state.motion == MOT_CLOSING) begin
                  state_next.position = (cfg.close_step >= state.position) ? '0
                                        : state.position - cfg.close_step;
               end
            end
            if (state_next.motion != MOT_IDLE && state_next.since_pub > PUBLISH_MS) begin
               result.publish       = 1'b1;
               state_next.since_pub = '0;
            end
         end
         FN_POSITION: begin
            if (target_sat != state.position) begin
               state_next.pending = (target_sat < state.position) ? TGT_CLOSE : TGT_OPEN;
            end
         end
         FN_STOP: begin
            if (state.motion != MOT_IDLE) begin
               state_next.pending = TGT_IDLE;
            end
         end
         FN_OPEN_HIT: begin
            state_next.pending  = TGT_NONE;
            state_next.motion   = MOT_IDLE;
            state_next.position = FULL_TRAVEL;
            state_next.prev_dir = DIR_OPENING;
            result.publish      = 1'b1;
         end
         FN_OPEN_LEFT: begin
            state_next.motion   = MOT_CLOSING;
            state_next.prev_dir = DIR_CLOSING;
            result.publish      = 1'b1;
         end
         FN_CLOSE_HIT: begin
            state_next.pending  = TGT_NONE;
            state_next.motion   = MOT_IDLE;
            state_next.position = '0;
            state_next.prev_dir = DIR_CLOSING;
            result.publish      = 1'b1;
         end
         FN_CLOSE_LEFT: begin
            state_next.motion   = MOT_OPENING;
            state_next.prev_dir = DIR_OPENING;
            result.publish      = 1'b1;
         end
         default: begin
         end
      endcase

      result.position = state_next.position;
      result.movement = state_next.motion;
   end

endmodule

[rtl/single_button_door_controller_core.sv]
// Single-button door controller. Every request word (a 1 ms tick, a position request, a stop
// or an endstop edge) yields exactly one response word carrying the estimated position, the
// motion, the button press and the publish flag. A word is taken on every clock unless req_tready
// is low; its state update is computed combinationally by the step logic, and the response is
// registered. A two-word output stage lets one more request be taken while a response is held
// up by the consumer; req_tready falls only when both output words are occupied.
// Configuration writes are applied at once and should be made while the block is idle.
module single_button_door_controller_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // func[2:0], target_position[27:3], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // position[24:0], movement[26:25], actuate[27], publish[28]
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [24:0] csr_wdata
);
   import sbdc_pkg::*;

   sbdc_cfg_type    cfg_ff;
   sbdc_state_type  state_ff;
   sbdc_state_type  state_in;
   sbdc_result_type result_in;
   sbdc_result_type out_ff;
   sbdc_result_type skid_ff;
   logic            out_valid_ff;
   logic            skid_valid_ff;
   logic            accept;
   logic            drain;

   sbdc_step u_step (
      .state           (state_ff),
      .cfg             (cfg_ff),
      .func            (req_tdata[2:0]),
      .target_position (req_tdata[27:3]),
      .state_next      (state_in),
      .result          (result_in)
   );

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign drain      = out_valid_ff && rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.open_step  <= STEP_RESET;
         cfg_ff.close_step <= STEP_RESET;
         cfg_ff.interval   <= IVL_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_OPEN_STEP:  cfg_ff.open_step  <= csr_wdata;
            CSR_CLOSE_STEP: cfg_ff.close_step <= csr_wdata;
            CSR_INTERVAL:   cfg_ff.interval   <= csr_wdata[IvlWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.position    <= HALF_TRAVEL;
         state_ff.motion      <= MOT_IDLE;
         state_ff.pending     <= TGT_NONE;
         state_ff.prev_dir    <= DIR_CLOSING;
         state_ff.since_press <= '0;
         state_ff.since_pub   <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // The skid word only fills while the output word is held, and drains into it first.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (drain) begin
         out_valid_ff  <= skid_valid_ff || accept;
         skid_valid_ff <= 1'b0;
      end else if (accept) begin
         out_valid_ff  <= 1'b1;
         skid_valid_ff <= out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (drain) begin
         out_ff <= skid_valid_ff ? skid_ff : result_in;
      end else if (accept && !out_valid_ff) begin
         out_ff <= result_in;
      end
      if (accept && out_valid_ff && !drain) begin
         skid_ff <= result_in;
      end
   end

   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held without an output word");

   a_position_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.position <= FULL_TRAVEL)
      else $error("door position beyond full travel");

   a_press_publishes: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.actuate) |-> out_ff.publish)
      else $error("button press without publish");

   a_motion_code: assert property (@(posedge clock) disable iff (reset)
      state_ff.motion != 2'd3)
      else $error("invalid motion code");

endmodule

[bench/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sbdc_pkg::*;

   localparam logic [2:0] FN_UNUSED    = 3'd7;
   localparam int         RandomWords  = 900;
   localparam int         RandomPhases = 8;
   localparam int         HoldCycles   = 300;

   typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_mode_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [31:0] req_tdata  = '0;
   logic        rsp_tready = 1'b0;
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_addr   = '0;
   logic [24:0] csr_wdata  = '0;
   wire         req_tready;
   wire         rsp_tvalid;
   wire  [31:0] rsp_tdata;

   single_button_door_controller_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // Shadow copy of the door state and its settings.
   logic [PosWidth-1:0]   m_pos         = HALF_TRAVEL;
   logic [1:0]            m_motion      = MOT_IDLE;
   logic [1:0]            m_pending     = TGT_NONE;
   logic                  m_prev_dir    = DIR_CLOSING;
   logic [PressWidth-1:0] m_since_press = '0;
   logic [PubWidth-1:0]   m_since_pub   = '0;
   logic [PosWidth-1:0]   m_open        = STEP_RESET;
   logic [PosWidth-1:0]   m_close       = STEP_RESET;
   logic [IvlWidth-1:0]   m_ivl         = IVL_RESET;

   sbdc_result_type expected_status[$];
   sbdc_result_type want_word;
   int unsigned     errors           = 0;
   int              burst_left       = 0;
   bit              hold_off_request = 1'b0;
   int              hold_left        = 0;
   rx_mode_type     rx_mode          = RX_ALWAYS;
   int              rx_left          = 0;
   int unsigned     rx_phase         = 0;

   function automatic sbdc_result_type door_step(input logic [2:0] fn,
                                                 input logic [PosWidth-1:0] tgt_in);
      logic [PosWidth-1:0] tgt;
      logic [PosWidth:0]   sum;
      sbdc_result_type     r;
      tgt = (tgt_in > FULL_TRAVEL) ? FULL_TRAVEL : tgt_in;
      r.actuate = 1'b0;
      r.publish = 1'b0;
      case (fn)
         FN_TICK: begin
            if (m_since_press < PRESS_MAX) m_since_press++;
            if (m_since_pub < PUB_MAX) m_since_pub++;
            if (m_pending != TGT_NONE && m_pending != m_motion) begin
               if (m_since_press > {1'b0, m_ivl}) begin
                  if (m_motion != MOT_IDLE) begin
                     m_motion = MOT_IDLE;
                  end else if (m_prev_dir == DIR_OPENING) begin
                     m_motion   = MOT_CLOSING;
                     m_prev_dir = DIR_CLOSING;
                  end else begin
                     m_motion   = MOT_OPENING;
                     m_prev_dir = DIR_OPENING;
                  end
                  r.actuate     = 1'b1;
                  r.publish     = 1'b1;
                  m_since_press = '0;
                  m_since_pub   = '0;
               end
            end else if (m_pending == m_motion) begin
               m_pending = TGT_NONE;
            end
            // The press tick itself adds no travel.
            if (!r.actuate) begin
               if (m_motion == MOT_OPENING) begin
                  sum   = {1'b0, m_pos} + {1'b0, m_open};
                  m_pos = (sum > {1'b0, FULL_TRAVEL}) ? FULL_TRAVEL : sum[PosWidth-1:0];
               end else if (m_motion == MOT_CLOSING) begin
                  m_pos = (m_close >= m_pos) ? '0 : m_pos - m_close;
               end
            end
            if (m_motion != MOT_IDLE && m_since_pub > PUBLISH_MS) begin
               r.publish   = 1'b1;
               m_since_pub = '0;
            end
         end
         FN_POSITION: begin
            if (tgt != m_pos) m_pending = (tgt < m_pos) ? TGT_CLOSE : TGT_OPEN;
         end
         FN_STOP: begin
            if (m_motion != MOT_IDLE) m_pending = TGT_IDLE;
         end
         FN_OPEN_HIT: begin
            m_pending  = TGT_NONE;
            m_motion   = MOT_IDLE;
            m_pos      = FULL_TRAVEL;
            m_prev_dir = DIR_OPENING;
            r.publish  = 1'b1;
         end
         FN_OPEN_LEFT: begin
            m_motion   = MOT_CLOSING;
            m_prev_dir = DIR_CLOSING;
            r.publish  = 1'b1;
         end
         FN_CLOSE_HIT: begin
            m_pending  = TGT_NONE;
            m_motion   = MOT_IDLE;
            m_pos      = '0;
            m_prev_dir = DIR_CLOSING;
            r.publish  = 1'b1;
         end
         FN_CLOSE_LEFT: begin
            m_motion   = MOT_OPENING;
            m_prev_dir = DIR_OPENING;
            r.publish  = 1'b1;
         end
         default: ;
      endcase
      r.position = m_pos;
      r.movement = m_motion;
      return r;
   endfunction

   // The sender works in bursts; valid stays high across a burst.
   task automatic send_word(input logic [2:0] fn, input logic [PosWidth-1:0] tgt);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, tgt, fn};
      do @(posedge clock); while (!req_tready);
      expected_status.push_back(door_step(fn, tgt));
   endtask

   task automatic drain_block();
      req_tvalid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic apply_config(input logic [PosWidth-1:0] open_step,
                               input logic [PosWidth-1:0] close_step,
                               input logic [IvlWidth-1:0] interval);
      drain_block();
      csr_we    <= 1'b1;
      csr_addr  <= CSR_OPEN_STEP;
      csr_wdata <= open_step;
      @(posedge clock);
      m_open     = open_step;
      csr_addr  <= CSR_CLOSE_STEP;
      csr_wdata <= close_step;
      @(posedge clock);
      m_close    = close_step;
      csr_addr  <= CSR_INTERVAL;
      csr_wdata <= {9'b0, interval};
      @(posedge clock);
      m_ivl      = interval;
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_word();
      int                  r;
      logic [2:0]          fn;
      logic [PosWidth-1:0] tgt;
      r   = $urandom_range(0, 99);
      tgt = PosWidth'($urandom());
      if (r < 55) begin
         fn = FN_TICK;
      end else if (r < 72) begin
         fn = FN_POSITION;
         case ($urandom_range(0, 5))
            2, 3:    tgt = PosWidth'($urandom_range(0, FULL_TRAVEL));
            4:       tgt = m_pos;
            5:       tgt = m_pos + PosWidth'($urandom_range(0, 4)) - PosWidth'(2);
            default: ;
         endcase
      end else if (r < 80) begin
         fn = FN_STOP;
      end else if (r < 82) begin
         fn = FN_UNUSED;
      end else begin
         case (r % 4)
            0:       fn = FN_OPEN_HIT;
            1:       fn = FN_OPEN_LEFT;
            2:       fn = FN_CLOSE_HIT;
            default: fn = FN_CLOSE_LEFT;
         endcase
      end
      send_word(fn, tgt);
   endtask

   // Runs on the settings left by reset.
   task automatic test_reset_state();
      send_word(FN_UNUSED, 25'h1FFFFFF);
      send_word(FN_STOP, '0);
      send_word(FN_TICK, '0);
      send_word(FN_POSITION, HALF_TRAVEL);
      send_word(FN_TICK, '0);
   endtask

   task automatic test_press_cycle();
      apply_config(FULL_TRAVEL, 25'd1, 16'd0);
      send_word(FN_POSITION, 25'h1FFFFFF);
      send_word(FN_TICK, '0);
      send_word(FN_TICK, '0);
      send_word(FN_TICK, '0);
      send_word(FN_STOP, '0);
      send_word(FN_TICK, '0);
      send_word(FN_POSITION, '0);
      send_word(FN_TICK, '0);
      send_word(FN_TICK, '0);
      send_word(FN_OPEN_HIT, '0);
      send_word(FN_OPEN_LEFT, '0);
      send_word(FN_CLOSE_HIT, '0);
      send_word(FN_CLOSE_LEFT, '0);
      send_word(FN_UNUSED, '0);
   endtask

   // A zero opening step and an oversized closing step, with a short interval.
   task automatic test_step_extremes();
      apply_config('0, 25'h1FFFFFF, 16'd2);
      send_word(FN_CLOSE_LEFT, '0);
      repeat (3) send_word(FN_TICK, '0);
      send_word(FN_STOP, '0);
      repeat (3) send_word(FN_TICK, '0);
      send_word(FN_POSITION, 25'h1FFFFFF);
      repeat (4) send_word(FN_TICK, '0);
   endtask

   task automatic test_publish_period();
      apply_config(25'd1, 25'd1, 16'hFFFF);
      send_word(FN_CLOSE_HIT, '0);
      send_word(FN_CLOSE_LEFT, '0);
      repeat (1010) send_word(FN_TICK, '0);
   endtask

   task automatic test_random_traffic();
      logic [PosWidth-1:0] o, c;
      logic [IvlWidth-1:0] iv;
      for (int phase = 0; phase < RandomPhases; phase++) begin
         case (phase)
            0:       begin o = 25'd1;        c = FULL_TRAVEL;  iv = 16'd0;    end
            1:       begin o = FULL_TRAVEL;  c = 25'd1;        iv = 16'hFFFF; end
            2:       begin o = '0;           c = '0;           iv = 16'd7;    end
            3:       begin o = 25'h1FFFFFF;  c = 25'h1FFFFFF;  iv = 16'd1;    end
            4:       begin o = PosWidth'($urandom()); c = PosWidth'($urandom());
                           iv = IvlWidth'($urandom_range(0, 30)); end
            default: begin o = PosWidth'($urandom_range(1, 1 << 22));
                           c = PosWidth'($urandom_range(1, 1 << 22));
                           iv = IvlWidth'($urandom_range(0, 30)); end
         endcase
         apply_config(o, c, iv);
         // One long hold-off on the response side while requests keep coming.
         if (phase == 2) hold_off_request = 1'b1;
         repeat (RandomWords / RandomPhases) random_word();
      end
   endtask

   // Response side: a fresh stall pattern every so often, or a long hold when asked.
   always @(posedge clock) begin
      if (hold_off_request) begin
         hold_off_request = 1'b0;
         hold_left        = HoldCycles;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (rx_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 160);
         end
         rx_left--;
         rx_phase++;
         case (rx_mode)
            RX_ALWAYS: rsp_tready <= 1'b1;
            RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
            RX_MOSTLY: rsp_tready <= ($urandom_range(0, 7) != 0);
            default:   rsp_tready <= ((rx_phase % 7) < 3);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_status.size() == 0) begin
            $display("%0t: response word with none expected, expected nothing, actual %h",
                     $time, rsp_tdata);
            errors++;
         end else begin
            want_word = expected_status.pop_front();
            if (rsp_tdata[24:0] !== want_word.position) begin
               $display("%0t: position expected %0d actual %0d",
                        $time, want_word.position, rsp_tdata[24:0]);
               errors++;
            end
            if (rsp_tdata[26:25] !== want_word.movement) begin
               $display("%0t: movement expected %0d actual %0d",
                        $time, want_word.movement, rsp_tdata[26:25]);
               errors++;
            end
            if (rsp_tdata[27] !== want_word.actuate) begin
               $display("%0t: actuate expected %0b actual %0b",
                        $time, want_word.actuate, rsp_tdata[27]);
               errors++;
            end
            if (rsp_tdata[28] !== want_word.publish) begin
               $display("%0t: publish expected %0b actual %0b",
                        $time, want_word.publish, rsp_tdata[28]);
               errors++;
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_press_cycle();
      test_step_extremes();
      test_publish_period();
      test_random_traffic();
      drain_block();
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[single_button_door_controller_core.f]
rtl/sbdc_pkg.sv
rtl/sbdc_step.sv
rtl/single_button_door_controller_core.sv
bench/tb.sv
